// ----- hdl/idi_pkg.sv -----
// Shared widths, register indexes and controller/datapath command and status types.
package idi_pkg;

  localparam int MAX_POINTS = 64;
  localparam int PTR_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = PTR_W + 1;

  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int POS_W      = 24;
  localparam int VEC_W      = 16;
  localparam int GRID_W     = 10;
  localparam int CELL_W     = 16;
  localparam int PWR_W      = 4;
  localparam int OFF_W      = GRID_W + CELL_W;
  localparam int Q_W        = OFF_W + 2;
  localparam int DX_W       = Q_W + 1;
  localparam int AX_W       = Q_W;
  localparam int SQ_W       = 2 * AX_W;
  localparam int SM2_W      = 2 * CELL_W;
  localparam int D2_W       = SQ_W + 2;
  localparam int BIT_W      = D2_W - 1;
  localparam int D_W        = D2_W / 2;
  localparam int MAN_W      = 32;
  localparam int PROD_W     = MAN_W + D_W;
  localparam int EXP_W      = 9;
  localparam int PRD_W      = MAN_W + VEC_W;
  localparam int ACC_W      = PRD_W + PTR_W;
  localparam int DEN_W      = MAN_W + PTR_W;
  localparam int QF_W       = VEC_W + 1;
  localparam int STEP_W     = 6;
  localparam int PWR_MAX    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_MIN_Z = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_PWR = 3'd4;

  typedef struct packed {
    logic accept;
    logic setup;
    logic delta;
    logic square;
    logic sum;
    logic take_vec;
    logic sqrt_step;
    logic pnorm;
    logic pmul;
    logic pshift;
    logic div_wt;
    logic wr_wt;
    logic ptr_zero;
    logic ptr_inc;
    logic amul;
    logic aadd;
    logic div_x;
    logic res_x;
    logic div_z;
    logic res_z;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic d2_zero;
    logic sqrt_last;
    logic p_one;
    logic pw_last;
    logic div_done;
    logic last_pt;
  } sts_t;

endpackage

// ----- hdl/idi_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module idi_div import idi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DEN_W-1:0]  rem_i,
  input  logic [MAN_W-1:0]  shin_i,
  input  logic [DEN_W-1:0]  dvs_i,
  input  logic [STEP_W-1:0] steps_i,
  output logic              done_o,
  output logic [MAN_W-1:0]  quo_o
);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DEN_W-1:0]  rem_q, dvs_q;
  logic [MAN_W-1:0]  sh_q, quo_q;
  logic [DEN_W:0]    trial, diff;
  logic              ge;

  assign trial = {rem_q, sh_q[MAN_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      sh_q  <= shin_i;
      dvs_q <= dvs_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[MAN_W-2:0], ge};
      sh_q  <= {sh_q[MAN_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- hdl/idi_dpath.sv -----
// Datapath: configuration, point tables, distance, root, power, weights and sums.
module idi_dpath import idi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    mode_i,
  input  logic [GRID_W-1:0]       grid_x_i,
  input  logic [GRID_W-1:0]       grid_z_i,
  input  logic signed [POS_W-1:0] point_x_i,
  input  logic signed [POS_W-1:0] point_z_i,
  input  logic signed [VEC_W-1:0] value_x_i,
  input  logic signed [VEC_W-1:0] value_z_i,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  output logic signed [VEC_W-1:0] result_x_o,
  output logic signed [VEC_W-1:0] result_z_o,
  output logic                    no_points_o,
  output logic                    add_refused_o
);

  localparam logic [DEN_W-1:0] WT_REM0 = DEN_W'(1) << (MAN_W - 2);

  // configuration and control state
  logic signed [POS_W-1:0] gmin_x_q, gmin_z_q;
  logic [CELL_W-1:0]       cell_q, smooth_q;
  logic [PWR_W-1:0]        pwr_q;
  logic [CNT_W-1:0]        count_q;
  logic [PTR_W-1:0]        ptr_q;
  logic                    full, empty;

  // memories
  logic [2*POS_W-1:0]       pos_mem [MAX_POINTS];
  logic [2*VEC_W-1:0]       vec_mem [MAX_POINTS];
  logic [EXP_W+MAN_W-1:0]   scr_mem [MAX_POINTS];
  logic [2*POS_W-1:0]       pos_rd_q;
  logic [2*VEC_W-1:0]       vec_rd_q;
  logic [EXP_W+MAN_W-1:0]   scr_rd_q;

  // payload
  logic [GRID_W-1:0]       gx_q, gz_q;
  logic signed [Q_W-1:0]   qx_q, qz_q;
  logic [SM2_W-1:0]        sm2_q;
  logic [PWR_W-1:0]        p_q;
  logic [AX_W-1:0]         ax_q, az_q;
  logic [SQ_W-1:0]         sqx_q, sqz_q;
  logic [D2_W-1:0]         n_q, root_q;
  logic [BIT_W-1:0]        bit_q;
  logic [D_W-1:0]          d_q;
  logic [MAN_W-1:0]        m_q;
  logic signed [EXP_W-1:0] e_q, emin_q;
  logic [PROD_W-1:0]       prod_q;
  logic [PWR_W-1:0]        kcnt_q;
  logic [MAN_W-1:0]        w_q;
  logic signed [PRD_W-1:0] px_q, pz_q;
  logic signed [ACC_W-1:0] numx_q, numz_q;
  logic [DEN_W-1:0]        den_q;
  logic signed [VEC_W-1:0] res_x_q, res_z_q, out_x_q, out_z_q;
  logic                    res_np_q, res_ar_q, out_np_q, out_ar_q;

  // combinational
  logic [OFF_W-1:0]        offx, offz;
  logic signed [DX_W-1:0]  dx, dz;
  logic [SQ_W-1:0]         sqx, sqz;
  logic [D2_W-1:0]         d2;
  logic [D2_W:0]           rb;
  logic [D_W-1:0]          dnew;
  logic [STEP_W-1:0]       blen, blen2, pshift;
  logic [MAN_W-1:0]        dext;
  logic signed [EXP_W:0]   ediff;
  logic [MAN_W-1:0]        wcur;
  logic signed [PRD_W:0]   mulx, mulz;
  logic [ACC_W-1:0]        magx, magz, dvd;
  logic                    div_start;
  logic [DEN_W-1:0]        div_rem, div_dvs;
  logic [MAN_W-1:0]        div_shin, quo;
  logic [STEP_W-1:0]       div_steps;
  logic                    div_done;

  assign full  = count_q == CNT_W'(MAX_POINTS);
  assign empty = count_q == '0;

  assign offx = OFF_W'(gx_q) * OFF_W'(cell_q);
  assign offz = OFF_W'(gz_q) * OFF_W'(cell_q);
  assign dx   = DX_W'(qx_q) - DX_W'($signed(pos_rd_q[2*POS_W-1:POS_W]));
  assign dz   = DX_W'(qz_q) - DX_W'($signed(pos_rd_q[POS_W-1:0]));
  assign sqx  = SQ_W'(ax_q) * SQ_W'(ax_q);
  assign sqz  = SQ_W'(az_q) * SQ_W'(az_q);
  assign d2   = D2_W'(sqx_q) + D2_W'(sqz_q) + D2_W'(sm2_q);
  assign rb   = {1'b0, root_q} + (D2_W+1)'(bit_q);
  assign dnew = root_q[D_W-1:0];
  assign dext = MAN_W'(dnew);

  always_comb begin
    blen = '0;
    for (int i = 0; i < D_W; i++) begin
      if (dnew[i]) blen = STEP_W'(i + 1);
    end
  end

  always_comb begin
    blen2 = '0;
    for (int i = 0; i < PROD_W; i++) begin
      if (prod_q[i]) blen2 = STEP_W'(i + 1);
    end
  end

  assign pshift = blen2 - STEP_W'(MAN_W);

  assign ediff = (EXP_W+1)'($signed(scr_rd_q[EXP_W+MAN_W-1:MAN_W])) - (EXP_W+1)'(emin_q);
  assign wcur  = (ediff > (EXP_W+1)'(62)) ? '0 : (scr_rd_q[MAN_W-1:0] >> ediff[5:0]);
  assign mulx  = $signed({1'b0, wcur}) * $signed(vec_rd_q[2*VEC_W-1:VEC_W]);
  assign mulz  = $signed({1'b0, wcur}) * $signed(vec_rd_q[VEC_W-1:0]);

  assign magx = numx_q[ACC_W-1] ? ACC_W'(-numx_q) : ACC_W'(numx_q);
  assign magz = numz_q[ACC_W-1] ? ACC_W'(-numz_q) : ACC_W'(numz_q);
  assign dvd  = (cmd_i.div_z ? magz : magx) + ACC_W'(den_q >> 1);

  assign div_start = cmd_i.div_wt | cmd_i.div_x | cmd_i.div_z;
  always_comb begin
    if (cmd_i.div_wt) begin
      div_rem   = WT_REM0;
      div_shin  = '0;
      div_dvs   = DEN_W'(m_q);
      div_steps = STEP_W'(MAN_W);
    end else begin
      div_rem   = DEN_W'(dvd >> QF_W);
      div_shin  = {dvd[QF_W-1:0], (MAN_W-QF_W)'(0)};
      div_dvs   = den_q;
      div_steps = STEP_W'(QF_W);
    end
  end

  idi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .shin_i  (div_shin),
    .dvs_i   (div_dvs),
    .steps_i (div_steps),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  function automatic logic signed [VEC_W-1:0] sat_q(input logic neg,
                                                     input logic [QF_W-1:0] q);
    logic signed [VEC_W-1:0] r;
    if (neg) begin
      r = (q >= QF_W'(32768)) ? 16'sh8000 : -$signed(q[VEC_W-1:0]);
    end else begin
      r = (q > QF_W'(32767)) ? 16'sh7fff : $signed(q[VEC_W-1:0]);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gmin_x_q <= '0;
      gmin_z_q <= '0;
      cell_q   <= CELL_W'(256);
      smooth_q <= '0;
      pwr_q    <= PWR_W'(2);
      count_q  <= '0;
      ptr_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GRID_MIN_X: gmin_x_q <= $signed(cfg_data_i[POS_W-1:0]);
          REG_GRID_MIN_Z: gmin_z_q <= $signed(cfg_data_i[POS_W-1:0]);
          REG_CELL_SIZE:  cell_q   <= cfg_data_i[CELL_W-1:0];
          REG_SMOOTHING:  smooth_q <= cfg_data_i[CELL_W-1:0];
          REG_WEIGHT_PWR: pwr_q    <= cfg_data_i[PWR_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept && !mode_i && !full) count_q <= count_q + 1'b1;
      if (cmd_i.setup || cmd_i.ptr_zero) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !mode_i && !full) begin
      pos_mem[count_q[PTR_W-1:0]] <= {point_x_i, point_z_i};
      vec_mem[count_q[PTR_W-1:0]] <= {value_x_i, value_z_i};
    end
    if (cmd_i.wr_wt) scr_mem[ptr_q] <= {e_q, quo};
    pos_rd_q <= pos_mem[ptr_q];
    vec_rd_q <= vec_mem[ptr_q];
    scr_rd_q <= scr_mem[ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      gx_q     <= grid_x_i;
      gz_q     <= grid_z_i;
      res_x_q  <= (mode_i && empty) ? 16'sh8000 : '0;
      res_z_q  <= (mode_i && empty) ? 16'sh8000 : '0;
      res_np_q <= mode_i && empty;
      res_ar_q <= !mode_i && full;
    end
    if (cmd_i.setup) begin
      qx_q   <= Q_W'(gmin_x_q) + $signed(Q_W'(offx));
      qz_q   <= Q_W'(gmin_z_q) + $signed(Q_W'(offz));
      sm2_q  <= SM2_W'(smooth_q) * SM2_W'(smooth_q);
      p_q    <= (pwr_q == '0) ? PWR_W'(1) :
                (pwr_q > PWR_W'(PWR_MAX)) ? PWR_W'(PWR_MAX) : pwr_q;
      numx_q <= '0;
      numz_q <= '0;
      den_q  <= '0;
    end
    if (cmd_i.delta) begin
      ax_q <= dx[DX_W-1] ? AX_W'(-dx) : AX_W'(dx);
      az_q <= dz[DX_W-1] ? AX_W'(-dz) : AX_W'(dz);
    end
    if (cmd_i.square) begin
      sqx_q <= sqx;
      sqz_q <= sqz;
    end
    if (cmd_i.sum) begin
      n_q    <= d2;
      root_q <= '0;
      bit_q  <= {1'b1, (BIT_W-1)'(0)};
    end
    if (cmd_i.take_vec) begin
      res_x_q <= $signed(vec_rd_q[2*VEC_W-1:VEC_W]);
      res_z_q <= $signed(vec_rd_q[VEC_W-1:0]);
    end
    if (cmd_i.sqrt_step) begin
      if ({1'b0, n_q} >= rb) begin
        n_q    <= n_q - rb[D2_W-1:0];
        root_q <= (root_q >> 1) + D2_W'(bit_q);
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.pnorm) begin
      d_q    <= dnew;
      m_q    <= dext << (STEP_W'(MAN_W) - blen);
      e_q    <= $signed(EXP_W'(blen)) - $signed(EXP_W'(MAN_W));
      kcnt_q <= PWR_W'(1);
    end
    if (cmd_i.pmul) prod_q <= PROD_W'(m_q) * PROD_W'(d_q);
    if (cmd_i.pshift) begin
      m_q    <= MAN_W'(prod_q >> pshift);
      e_q    <= e_q + $signed(EXP_W'(pshift));
      kcnt_q <= kcnt_q + 1'b1;
    end
    if (cmd_i.wr_wt && (ptr_q == '0 || e_q < emin_q)) emin_q <= e_q;
    if (cmd_i.amul) begin
      w_q  <= wcur;
      px_q <= mulx[PRD_W-1:0];
      pz_q <= mulz[PRD_W-1:0];
    end
    if (cmd_i.aadd) begin
      numx_q <= numx_q + ACC_W'(px_q);
      numz_q <= numz_q + ACC_W'(pz_q);
      den_q  <= den_q + DEN_W'(w_q);
    end
    if (cmd_i.res_x) res_x_q <= sat_q(numx_q[ACC_W-1], quo[QF_W-1:0]);
    if (cmd_i.res_z) res_z_q <= sat_q(numz_q[ACC_W-1], quo[QF_W-1:0]);
    if (cmd_i.load_out) begin
      out_x_q  <= res_x_q;
      out_z_q  <= res_z_q;
      out_np_q <= res_np_q;
      out_ar_q <= res_ar_q;
    end
  end

  assign sts_o.empty     = empty;
  assign sts_o.d2_zero   = d2 == '0;
  assign sts_o.sqrt_last = bit_q[0];
  assign sts_o.p_one     = p_q == PWR_W'(1);
  assign sts_o.pw_last   = (kcnt_q + 1'b1) == p_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.last_pt   = ptr_q == PTR_W'(count_q - 1'b1);

  assign result_x_o    = out_x_q;
  assign result_z_o    = out_z_q;
  assign no_points_o   = out_np_q;
  assign add_refused_o = out_ar_q;

endmodule

// ----- hdl/idi_ctrl.sv -----
// Controller: sequences adds, the per-point weight pass, the sum pass and the final divides.
module idi_ctrl import idi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic mode_i,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_SETUP  = 20'h00002,
    S_RD     = 20'h00004,
    S_DX     = 20'h00008,
    S_SQ     = 20'h00010,
    S_SUM    = 20'h00020,
    S_SQRT   = 20'h00040,
    S_PNORM  = 20'h00080,
    S_PMUL   = 20'h00100,
    S_PSHIFT = 20'h00200,
    S_DIVST  = 20'h00400,
    S_DIVW   = 20'h00800,
    S_ARD    = 20'h01000,
    S_AMUL   = 20'h02000,
    S_AADD   = 20'h04000,
    S_FXST   = 20'h08000,
    S_FXW    = 20'h10000,
    S_FZST   = 20'h20000,
    S_FZW    = 20'h40000,
    S_DONE   = 20'h80000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = (mode_i && !sts_i.empty) ? S_SETUP : S_DONE;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d = S_RD;
      end
      S_RD: state_d = S_DX;
      S_DX: begin
        cmd_o.delta = 1'b1;
        state_d = S_SQ;
      end
      S_SQ: begin
        cmd_o.square = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        if (sts_i.d2_zero) begin
          cmd_o.take_vec = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_last) state_d = S_PNORM;
      end
      S_PNORM: begin
        cmd_o.pnorm = 1'b1;
        state_d = sts_i.p_one ? S_DIVST : S_PMUL;
      end
      S_PMUL: begin
        cmd_o.pmul = 1'b1;
        state_d = S_PSHIFT;
      end
      S_PSHIFT: begin
        cmd_o.pshift = 1'b1;
        state_d = sts_i.pw_last ? S_DIVST : S_PMUL;
      end
      S_DIVST: begin
        cmd_o.div_wt = 1'b1;
        state_d = S_DIVW;
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          cmd_o.wr_wt = 1'b1;
          if (sts_i.last_pt) begin
            cmd_o.ptr_zero = 1'b1;
            state_d = S_ARD;
          end else begin
            cmd_o.ptr_inc = 1'b1;
            state_d = S_RD;
          end
        end
      end
      S_ARD: state_d = S_AMUL;
      S_AMUL: begin
        cmd_o.amul = 1'b1;
        state_d = S_AADD;
      end
      S_AADD: begin
        cmd_o.aadd = 1'b1;
        if (sts_i.last_pt) begin
          state_d = S_FXST;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d = S_ARD;
        end
      end
      S_FXST: begin
        cmd_o.div_x = 1'b1;
        state_d = S_FXW;
      end
      S_FXW: begin
        if (sts_i.div_done) begin
          cmd_o.res_x = 1'b1;
          state_d = S_FZST;
        end
      end
      S_FZST: begin
        cmd_o.div_z = 1'b1;
        state_d = S_FZW;
      end
      S_FZW: begin
        if (sts_i.div_done) begin
          cmd_o.res_z = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/inverse_distance_interpolator_core.sv -----
// Top level of the inverse-distance vector interpolator.
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_we_i               cfg_idx_i, cfg_data_i
//   in        in         in_valid_i/in_ready_o  mode_i, grid_*_i, point_*_i, value_*_i
//   out       out        out_valid_o/out_ready_i result_*_o, no_points_o, add_refused_o
//
// An add beat or a query on an empty table goes from the idle state straight to the done state.
// A query over N points runs a weight pass and a sum pass over all N points and two final divides,
// its length set by the one-bit-per-cycle root and the shared one-bit-per-cycle divider.
// A new beat is taken while the previous result still waits in the output register.
// No clearing pass after reset; the point count, pointer and config registers are reset, the tables are not.
module inverse_distance_interpolator_core import idi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    mode_i,
  input  logic [GRID_W-1:0]       grid_x_i,
  input  logic [GRID_W-1:0]       grid_z_i,
  input  logic signed [POS_W-1:0] point_x_i,
  input  logic signed [POS_W-1:0] point_z_i,
  input  logic signed [VEC_W-1:0] value_x_i,
  input  logic signed [VEC_W-1:0] value_z_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [VEC_W-1:0] result_x_o,
  output logic signed [VEC_W-1:0] result_z_o,
  output logic                    no_points_o,
  output logic                    add_refused_o
);

  cmd_t cmd;
  sts_t sts;

  idi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (mode_i),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  idi_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .mode_i        (mode_i),
    .grid_x_i      (grid_x_i),
    .grid_z_i      (grid_z_i),
    .point_x_i     (point_x_i),
    .point_z_i     (point_z_i),
    .value_x_i     (value_x_i),
    .value_z_i     (value_z_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .result_x_o    (result_x_o),
    .result_z_o    (result_z_o),
    .no_points_o   (no_points_o),
    .add_refused_o (add_refused_o)
  );

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(no_points_o && add_refused_o))
    else $error("empty-table and refused flags both set");

  a_empty_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && no_points_o) |-> (result_x_o == 16'sh8000 && result_z_o == 16'sh8000))
    else $error("empty-table result is not most negative");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && add_refused_o) |-> (result_x_o == '0 && result_z_o == '0))
    else $error("refused add carries a nonzero vector");

endmodule

// ----- tb/sv/idi_checker.sv -----
// Checker for the interpolator: watches the config, input and output channels, predicts and compares.
`timescale 1ns / 100ps
module idi_checker import idi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    mode_i,
  input  logic [GRID_W-1:0]       grid_x_i,
  input  logic [GRID_W-1:0]       grid_z_i,
  input  logic signed [POS_W-1:0] point_x_i,
  input  logic signed [POS_W-1:0] point_z_i,
  input  logic signed [VEC_W-1:0] value_x_i,
  input  logic signed [VEC_W-1:0] value_z_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [VEC_W-1:0] result_x_i,
  input  logic signed [VEC_W-1:0] result_z_i,
  input  logic                    no_points_i,
  input  logic                    add_refused_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic signed [VEC_W-1:0] rx;
    logic signed [VEC_W-1:0] rz;
    logic                    empty;
    logic                    refused;
  } answer_t;

  answer_t answers_q[$];

  logic signed [POS_W-1:0] origin_x, origin_z;
  logic [CELL_W-1:0]       pitch, smooth;
  logic [PWR_W-1:0]        power;
  longint                  tab_px[MAX_POINTS], tab_pz[MAX_POINTS];
  longint                  tab_vx[MAX_POINTS], tab_vz[MAX_POINTS];
  int                      npoints;

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [VEC_W-1:0] clip16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[VEC_W-1:0];
  endfunction

  function automatic longint div_nearest(longint num, longint unsigned den);
    longint unsigned mag, q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic answer_t interpolate(logic [GRID_W-1:0] gx, logic [GRID_W-1:0] gz);
    answer_t a;
    longint qx, qz, dx, dz, nx, nz, emin;
    longint unsigned d2, d, m, s2, den, w;
    longint unsigned man[MAX_POINTS];
    int ex[MAX_POINTS];
    int e, p, sh;
    a = '0;
    if (npoints == 0) begin
      a.rx = 16'sh8000;
      a.rz = 16'sh8000;
      a.empty = 1'b1;
      return a;
    end
    p = power == 0 ? 1 : (power > PWR_MAX ? PWR_MAX : power);
    qx = longint'(origin_x) + longint'(gx) * longint'(pitch);
    qz = longint'(origin_z) + longint'(gz) * longint'(pitch);
    s2 = longint'(smooth) * longint'(smooth);
    emin = 0;
    for (int i = 0; i < npoints; i++) begin
      dx = qx - tab_px[i];
      dz = qz - tab_pz[i];
      if (dx < 0) dx = -dx;
      if (dz < 0) dz = -dz;
      d2 = dx * dx + dz * dz + s2;
      if (d2 == 0) begin
        a.rx = clip16(tab_vx[i]);
        a.rz = clip16(tab_vz[i]);
        return a;
      end
      d = int_root(d2);
      m = d;
      e = 0;
      for (int k = 0; k < p; k++) begin
        if (k > 0) m = m * d;
        while (m >= (64'd1 << 32)) begin m = m >> 1; e++; end
        while (m < (64'd1 << 31)) begin m = m << 1; e--; end
      end
      man[i] = (64'd1 << 62) / m;
      ex[i] = e;
      if (i == 0 || e < emin) emin = e;
    end
    nx = 0;
    nz = 0;
    den = 0;
    for (int i = 0; i < npoints; i++) begin
      sh = ex[i] - emin;
      w = sh >= 63 ? 0 : (man[i] >> sh);
      nx += longint'(w) * tab_vx[i];
      nz += longint'(w) * tab_vz[i];
      den += w;
    end
    if (den == 0) den = 1;
    a.rx = clip16(div_nearest(nx, den));
    a.rz = clip16(div_nearest(nz, den));
    return a;
  endfunction

  assign pending_o = answers_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t a, got;
    if (!rst_ni) begin
      origin_x <= '0;
      origin_z <= '0;
      pitch <= 16'd256;
      smooth <= '0;
      power <= 4'd2;
      npoints = 0;
      fail_count_o <= 0;
      answers_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GRID_MIN_X: origin_x <= cfg_data_i;
          REG_GRID_MIN_Z: origin_z <= cfg_data_i;
          REG_CELL_SIZE:  pitch <= cfg_data_i[CELL_W-1:0];
          REG_SMOOTHING:  smooth <= cfg_data_i[CELL_W-1:0];
          REG_WEIGHT_PWR: power <= cfg_data_i[PWR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        a = '0;
        if (mode_i) begin
          a = interpolate(grid_x_i, grid_z_i);
        end else if (npoints >= MAX_POINTS) begin
          a.refused = 1'b1;
        end else begin
          tab_px[npoints] = point_x_i;
          tab_pz[npoints] = point_z_i;
          tab_vx[npoints] = value_x_i;
          tab_vz[npoints] = value_z_i;
          npoints++;
        end
        answers_q.insert(answers_q.size(), a);
      end
      if (out_valid_i && out_ready_i) begin
        got = '{result_x_i, result_z_i, no_points_i, add_refused_i};
        if (answers_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          a = answers_q.pop_front();
          if (a !== got) begin
            $display("%0t: expected x=%0d z=%0d np=%b ar=%b, actual x=%0d z=%0d np=%b ar=%b",
                     $time, a.rx, a.rz, a.empty, a.refused,
                     got.rx, got.rz, got.empty, got.refused);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/sv/tb_inverse_distance_interpolator_core.sv -----
// Testbench top for the interpolator: stimulus, idling phases and verdict.
`timescale 1ns / 100ps
module tb_inverse_distance_interpolator_core;
  import idi_pkg::*;

  logic                    clk_i, rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_W-1:0]        cfg_data_i;
  logic                    in_valid_i, in_ready_o;
  logic                    mode_i;
  logic [GRID_W-1:0]       grid_x_i, grid_z_i;
  logic signed [POS_W-1:0] point_x_i, point_z_i;
  logic signed [VEC_W-1:0] value_x_i, value_z_i;
  logic                    out_valid_o, out_ready_i;
  logic signed [VEC_W-1:0] result_x_o, result_z_o;
  logic                    no_points_o, add_refused_o;
  int                      fail_count, pending;
  int                      send_idle_pct, recv_idle_pct;

  inverse_distance_interpolator_core uut (.*);

  idi_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .mode_i, .grid_x_i, .grid_z_i,
    .point_x_i, .point_z_i, .value_x_i, .value_z_i,
    .out_valid_i(out_valid_o), .out_ready_i, .result_x_i(result_x_o),
    .result_z_i(result_z_o), .no_points_i(no_points_o), .add_refused_i(add_refused_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i  <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_beat(logic m, logic [GRID_W-1:0] gx, logic [GRID_W-1:0] gz,
                           logic [POS_W-1:0] px, logic [POS_W-1:0] pz,
                           logic [VEC_W-1:0] vx, logic [VEC_W-1:0] vz);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_valid_i <= 1'b1;
    mode_i <= m;
    grid_x_i <= gx;
    grid_z_i <= gz;
    point_x_i <= px;
    point_z_i <= pz;
    value_x_i <= vx;
    value_z_i <= vz;
    do @(posedge clk_i); while (!in_ready_o);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic add_point(logic [POS_W-1:0] px, logic [POS_W-1:0] pz);
    send_beat(1'b0, GRID_W'($urandom), GRID_W'($urandom), px, pz,
              VEC_W'($urandom), VEC_W'($urandom));
  endtask

  task automatic query_cell(logic [GRID_W-1:0] gx, logic [GRID_W-1:0] gz);
    send_beat(1'b1, gx, gz, POS_W'($urandom), POS_W'($urandom),
              VEC_W'($urandom), VEC_W'($urandom));
  endtask

  task automatic random_config();
    write_reg(REG_GRID_MIN_X, CFG_W'($urandom));
    write_reg(REG_GRID_MIN_Z, CFG_W'($urandom));
    write_reg(REG_CELL_SIZE, CFG_W'($urandom_range(1, 65535)));
    write_reg(REG_SMOOTHING, ($urandom_range(0, 3) == 0) ? '0 :
                             CFG_W'($urandom_range(0, 65535)));
    write_reg(REG_WEIGHT_PWR, CFG_W'($urandom_range(0, 15)));
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; mode_i = 1'b0; grid_x_i = '0; grid_z_i = '0;
    point_x_i = '0; point_z_i = '0; value_x_i = '0; value_z_i = '0;
    out_ready_i = 1'b0;
    send_idle_pct = 36; recv_idle_pct = 62;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, exact hit, extremes
    query_cell(10'd0, 10'd0);
    send_beat(1'b0, '0, '0, 24'd256, 24'd512, 16'sh7fff, 16'sh8000);
    add_point(24'h800000, 24'h7fffff);
    send_beat(1'b0, '0, '0, 24'd256, 24'd512, 16'sh0100, 16'sh0100);
    query_cell(10'd1, 10'd2);
    query_cell(10'd1023, 10'd1023);
    query_cell(10'd0, 10'd0);
    drain();
    write_reg(REG_GRID_MIN_X, 24'h800000);
    write_reg(REG_GRID_MIN_Z, 24'h7fffff);
    write_reg(REG_CELL_SIZE, 24'hffff);
    write_reg(REG_SMOOTHING, 24'hffff);
    write_reg(REG_WEIGHT_PWR, 24'd8);
    query_cell(10'd1023, 10'd0);
    query_cell(10'd0, 10'd1023);
    drain();
    write_reg(REG_CELL_SIZE, 24'd1);
    write_reg(REG_SMOOTHING, 24'd0);
    write_reg(REG_WEIGHT_PWR, 24'd1);
    query_cell(10'd512, 10'd5);
    drain();
    write_reg(REG_WEIGHT_PWR, 24'd0);
    query_cell(10'd3, 10'd700);
    drain();
    write_reg(REG_WEIGHT_PWR, 24'd15);
    query_cell(10'd3, 10'd700);
    drain();

    // random: few points at first, mostly queries
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 36 : (phase == 1 ? 62 : 0);
      recv_idle_pct = phase == 0 ? 62 : (phase == 1 ? 36 : 0);
      for (int blk = 0; blk < 10; blk++) begin
        drain();
        random_config();
        for (int j = 0; j < 50; j++) begin
          if ($urandom_range(0, 9) < 3)
            add_point(POS_W'($urandom), POS_W'($urandom));
          else
            query_cell(GRID_W'($urandom_range(0, 1023)), GRID_W'($urandom_range(0, 1023)));
        end
      end
    end

    // fill the table and overflow it
    repeat (70) add_point(POS_W'($urandom), POS_W'($urandom));
    query_cell(GRID_W'($urandom), GRID_W'($urandom));
    query_cell(10'd1023, 10'd0);
    drain();
    repeat (200) @(posedge clk_i);

    if (fail_count == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/idi_pkg.sv
hdl/idi_div.sv
hdl/idi_dpath.sv
hdl/idi_ctrl.sv
hdl/inverse_distance_interpolator_core.sv
tb/sv/idi_checker.sv
tb/sv/tb_inverse_distance_interpolator_core.sv
